// ----- hw/rtl/etr_pkg.sv -----
// Shared types and constants for the event timer register block.
package etr_pkg;

  // Timer count limits and interrupt line count.
  localparam int unsigned NUM_TIMERS_DEF = 3;
  localparam int unsigned MAX_TIMERS     = 8;
  localparam int unsigned NUM_LINES      = 3;
  localparam int unsigned TSEL_W         = 3;

  // Configuration register defaults and widths.
  localparam int unsigned PERIOD_W       = 27;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam logic [PERIOD_W-1:0] PERIOD_FS_RST = 27'd69841279;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_FS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_IS_64  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEGACY_CAPABLE = 2'd2;

  // Operation codes.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register word indexes.
  localparam logic [5:0] IDX_CAPS    = 6'h00;
  localparam logic [5:0] IDX_GENERAL = 6'h02;
  localparam logic [5:0] IDX_STATUS  = 6'h04;
  localparam logic [5:0] IDX_COUNTER = 6'h1e;
  localparam logic [1:0] SUB_CONFIG  = 2'd0;
  localparam logic [1:0] SUB_COMPARE = 2'd1;

  // Timer config bit positions.
  localparam int unsigned TCFG_LEVEL_BIT   = 1;
  localparam int unsigned TCFG_ENABLE_BIT  = 2;
  localparam int unsigned TCFG_FORCE32_BIT = 8;

  localparam logic [7:0] REVISION = 8'h01;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  reg_index;
    logic [63:0] write_data;
  } in_beat_t;

  typedef struct packed {
    logic [63:0]          read_data;
    logic [NUM_LINES-1:0] irq_lines;
    logic                 legacy_route;
  } out_beat_t;

  typedef struct packed {
    logic tick;
    logic cfg_we;
    logic cmp_we;
    logic c64;
  } timer_ctl_t;

  typedef struct packed {
    logic level;
    logic irq_en;
    logic force32;
    logic match;
  } timer_stat_t;

endpackage

// ----- hw/rtl/event_timer_register_block.sv -----
// Event timer register block top level: beat registers and configuration.
// Path: a beat is taken into the input register, moves into the result
// register when the core advances and is offered on the output from then on.
// Throughput: one beat per cycle while the output is not stalled; the core
// works in one pass between the input register and the result register.
// Reset: counter, enables, status and timer config clear; comparators go all ones.
module event_timer_register_block #(
  parameter int unsigned NUM_TIMERS = etr_pkg::NUM_TIMERS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  etr_pkg::in_beat_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output etr_pkg::out_beat_t               out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [etr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [etr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic                         in_vld_q, out_vld_q, adv;
  etr_pkg::in_beat_t            in_q;
  etr_pkg::out_beat_t           out_q, res;
  logic [etr_pkg::PERIOD_W-1:0] period_q;
  logic                         c64_q, lc_q;

  assign adv         = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || adv;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  etr_core #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .go_i            (adv),
    .beat_i          (in_q),
    .period_fs_i     (period_q),
    .counter_is_64_i (c64_q),
    .legacy_capable_i(lc_q),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= etr_pkg::PERIOD_FS_RST;
      c64_q    <= 1'b1;
      lc_q     <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        etr_pkg::CFG_PERIOD_FS:      period_q <= cfg_data_i[etr_pkg::PERIOD_W-1:0];
        etr_pkg::CFG_COUNTER_IS_64:  c64_q    <= cfg_data_i[0];
        etr_pkg::CFG_LEGACY_CAPABLE: lc_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/etr_timer.sv -----
// One comparator timer: config bits, comparator and match detect.
module etr_timer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  etr_pkg::timer_ctl_t ctl_i,
  input  logic [63:0]         cnt_i,
  input  logic [63:0]         wdata_i,
  output etr_pkg::timer_stat_t stat_o,
  output logic [63:0]         cmp_rd_o
);

  logic        level_q, irq_en_q, force32_q;
  logic [63:0] cmp_q, cmp_d;
  logic        is32;
  logic        match;

  assign is32 = force32_q | ~ctl_i.c64;

  always_comb begin
    cmp_d = is32 ? {32'h0, wdata_i[31:0]} : wdata_i;
    if (is32) begin
      match = ctl_i.tick && (cnt_i[31:0] == cmp_q[31:0]);
    end else begin
      match = ctl_i.tick && (cnt_i == cmp_q);
    end
  end

  assign cmp_rd_o       = is32 ? {32'h0, cmp_q[31:0]} : cmp_q;
  assign stat_o.level   = level_q;
  assign stat_o.irq_en  = irq_en_q;
  assign stat_o.force32 = force32_q;
  assign stat_o.match   = match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= 1'b0;
      irq_en_q  <= 1'b0;
      force32_q <= 1'b0;
      cmp_q     <= '1;
    end else begin
      if (ctl_i.cfg_we) begin
        level_q   <= wdata_i[etr_pkg::TCFG_LEVEL_BIT];
        irq_en_q  <= wdata_i[etr_pkg::TCFG_ENABLE_BIT];
        force32_q <= wdata_i[etr_pkg::TCFG_FORCE32_BIT];
      end
      if (ctl_i.cmp_we) begin
        cmp_q <= cmp_d;
      end
    end
  end

endmodule

// ----- hw/rtl/etr_core.sv -----
// Register file, main counter, status and per-beat result logic.
module etr_core #(
  parameter int unsigned NUM_TIMERS = etr_pkg::NUM_TIMERS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           go_i,
  input  etr_pkg::in_beat_t              beat_i,
  input  logic [etr_pkg::PERIOD_W-1:0]   period_fs_i,
  input  logic                           counter_is_64_i,
  input  logic                           legacy_capable_i,
  output etr_pkg::out_beat_t             res_o
);

  localparam int unsigned LINE_CNT =
    (NUM_TIMERS < etr_pkg::NUM_LINES) ? NUM_TIMERS : etr_pkg::NUM_LINES;

  logic [63:0]                   cnt_q, cnt_d, cnt_inc, cnt_rd;
  logic [1:0]                    ge_q, ge_d;
  logic [etr_pkg::NUM_LINES-1:0] st_q, st_d;
  logic [etr_pkg::NUM_LINES-1:0] pulses, lines;
  logic                          is_tick, is_read, is_write;
  logic [etr_pkg::TSEL_W-1:0]    tsel;
  logic [1:0]                    tsub;
  logic [63:0]                   caps, rd;
  logic [63:0]                   wdata;

  etr_pkg::timer_ctl_t  ctl  [NUM_TIMERS];
  etr_pkg::timer_stat_t stat [NUM_TIMERS];
  logic [63:0]          cmp_rd [NUM_TIMERS];

  assign wdata    = beat_i.write_data;
  assign is_tick  = go_i && (beat_i.op == etr_pkg::OP_TICK) && ge_q[0];
  assign is_read  = go_i && (beat_i.op == etr_pkg::OP_READ);
  assign is_write = go_i && (beat_i.op == etr_pkg::OP_WRITE);
  assign tsel     = beat_i.reg_index[4:2];
  assign tsub     = beat_i.reg_index[1:0];

  assign cnt_inc = counter_is_64_i ? (cnt_q + 64'd1) : {32'h0, cnt_q[31:0] + 32'd1};
  assign cnt_rd  = counter_is_64_i ? cnt_q : {32'h0, cnt_q[31:0]};

  assign caps = {5'h0, period_fs_i, 16'h0, legacy_capable_i, 1'b0, counter_is_64_i,
                 5'(NUM_TIMERS - 1), etr_pkg::REVISION};

  for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
    logic hit;
    assign hit = is_write && beat_i.reg_index[5] && (tsel == etr_pkg::TSEL_W'(t));
    assign ctl[t].tick   = is_tick;
    assign ctl[t].cfg_we = hit && (tsub == etr_pkg::SUB_CONFIG);
    assign ctl[t].cmp_we = hit && (tsub == etr_pkg::SUB_COMPARE);
    assign ctl[t].c64    = counter_is_64_i;

    etr_timer u_timer (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[t]),
      .cnt_i   (cnt_inc),
      .wdata_i (wdata),
      .stat_o  (stat[t]),
      .cmp_rd_o(cmp_rd[t])
    );
  end

  always_comb begin
    rd = '0;
    if (is_read) begin
      case (beat_i.reg_index)
        etr_pkg::IDX_CAPS:    rd = caps;
        etr_pkg::IDX_GENERAL: rd = {62'h0, ge_q};
        etr_pkg::IDX_STATUS:  rd = {61'h0, st_q};
        etr_pkg::IDX_COUNTER: rd = cnt_rd;
        default: begin
          for (int t = 0; t < NUM_TIMERS; t++) begin
            if (beat_i.reg_index[5] && (tsel == etr_pkg::TSEL_W'(t))) begin
              if (tsub == etr_pkg::SUB_CONFIG) begin
                rd = 64'(stat[t].force32) << etr_pkg::TCFG_FORCE32_BIT
                   | 64'(stat[t].irq_en) << etr_pkg::TCFG_ENABLE_BIT
                   | 64'(stat[t].level) << etr_pkg::TCFG_LEVEL_BIT;
              end else if (tsub == etr_pkg::SUB_COMPARE) begin
                rd = cmp_rd[t];
              end
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    logic lvl_n, en_n;
    ge_d   = ge_q;
    st_d   = st_q;
    cnt_d  = cnt_q;
    pulses = '0;
    lines  = '0;
    if (is_write) begin
      case (beat_i.reg_index)
        etr_pkg::IDX_GENERAL: ge_d  = wdata[1:0];
        etr_pkg::IDX_STATUS:  st_d  = st_q & ~wdata[etr_pkg::NUM_LINES-1:0];
        etr_pkg::IDX_COUNTER: cnt_d = counter_is_64_i ? wdata : {32'h0, wdata[31:0]};
        default: ;
      endcase
    end
    if (is_tick) begin
      cnt_d = cnt_inc;
    end
    for (int t = 0; t < LINE_CNT; t++) begin
      if (stat[t].match) begin
        if (stat[t].level) begin
          st_d[t] = 1'b1;
        end else if (stat[t].irq_en) begin
          pulses[t] = 1'b1;
        end
      end
    end
    for (int t = 0; t < LINE_CNT; t++) begin
      lvl_n = ctl[t].cfg_we ? wdata[etr_pkg::TCFG_LEVEL_BIT] : stat[t].level;
      en_n  = ctl[t].cfg_we ? wdata[etr_pkg::TCFG_ENABLE_BIT] : stat[t].irq_en;
      lines[t] = ge_d[0] && lvl_n && en_n && st_d[t];
    end
  end

  assign res_o.read_data    = rd;
  assign res_o.irq_lines    = lines | pulses;
  assign res_o.legacy_route = ge_d[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ge_q  <= '0;
      st_q  <= '0;
    end else if (go_i) begin
      cnt_q <= cnt_d;
      ge_q  <= ge_d;
      st_q  <= st_d;
    end
  end

endmodule
